FILE: src/integer_array_sort_search_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer array sort and search block
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ARRAY_SORT_SEARCH_MACROS_SVH
`define INTEGER_ARRAY_SORT_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the cycle after the antecedent.
`define IASS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define IASS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define IASS_ASSERT_NEXT(lbl, ante, cons)
`define IASS_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

FILE: src/iass_pkg.sv
// ----------------------------------------------------------------------------
// iass_pkg
// Shared types, constants and codes of the integer array sort and search block.
// ----------------------------------------------------------------------------
package iass_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int MIN_RUN_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int STACK_DEPTH = 64;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = STK_AW + 1;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 17;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 11;
  localparam int BASE_W = 16;
  localparam int CFG_W  = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // Configuration register indexes.
  localparam logic REG_ARRAY_SIZE = 1'b0;
  localparam logic REG_INDEX_BASE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [26:0] {
    ST_IDLE     = 27'd1 << 0,
    ST_DECODE   = 27'd1 << 1,
    ST_RD       = 27'd1 << 2,
    ST_S_LOOP   = 27'd1 << 3,
    ST_S_CMP    = 27'd1 << 4,
    ST_S_END    = 27'd1 << 5,
    ST_Q_POP    = 27'd1 << 6,
    ST_Q_POPW   = 27'd1 << 7,
    ST_Q_M1     = 27'd1 << 8,
    ST_Q_M2     = 27'd1 << 9,
    ST_Q_M3     = 27'd1 << 10,
    ST_Q_M4     = 27'd1 << 11,
    ST_Q_I      = 27'd1 << 12,
    ST_Q_IC     = 27'd1 << 13,
    ST_Q_KC     = 27'd1 << 14,
    ST_Q_SW2    = 27'd1 << 15,
    ST_Q_FIN    = 27'd1 << 16,
    ST_Q_PUSH2  = 27'd1 << 17,
    ST_I_START  = 27'd1 << 18,
    ST_I_SCAN   = 27'd1 << 19,
    ST_I_SWAP   = 27'd1 << 20,
    ST_I_SWAP2  = 27'd1 << 21,
    ST_I_NEXT   = 27'd1 << 22,
    ST_I_SAVE   = 27'd1 << 23,
    ST_I_CMP    = 27'd1 << 24,
    ST_I_PUT    = 27'd1 << 25,
    ST_FINISH   = 27'd1 << 26
  } ctl_state_t;

  typedef struct packed {
    ctl_state_t op;
    logic       accept;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic bad_idx;
    logic bad_rng;
    logic single;
    logic s_more;
    logic s_eq;
    logic stk_empty;
    logic q_degen;
    logic i_more;
    logic k_more;
    logic ik_lt;
    logic push2;
    logic scan_last;
    logic is_done;
    logic is_shift;
    logic is_cont;
  } dp_status_t;

endpackage

FILE: src/iass_ctrl.sv
// ----------------------------------------------------------------------------
// iass_ctrl
// Sequencer for commands, partition passes, insertion sort and search.
// ----------------------------------------------------------------------------
`include "integer_array_sort_search_macros.svh"

module iass_ctrl
  import iass_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t st
);

  ctl_state_t state, state_next;
  logic       slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  assign cmd.op       = state;
  assign cmd.accept   = s_tvalid && s_tready;
  assign cmd.load_out = (state == ST_FINISH) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (st.cmd)
          CMD_WRITE:  state_next = ST_FINISH;
          CMD_READ:   state_next = st.bad_idx ? ST_FINISH : ST_RD;
          CMD_SORT:   state_next = (st.bad_rng || st.single) ? ST_FINISH : ST_Q_POP;
          CMD_SEARCH: state_next = ST_S_LOOP;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_RD:      state_next = ST_FINISH;
      ST_S_LOOP:  state_next = st.s_more ? ST_S_CMP : ST_S_END;
      ST_S_CMP:   state_next = st.s_eq ? ST_FINISH : ST_S_LOOP;
      ST_S_END:   state_next = ST_FINISH;
      ST_Q_POP:   state_next = st.stk_empty ? ST_I_START : ST_Q_POPW;
      ST_Q_POPW:  state_next = st.q_degen ? ST_Q_POP : ST_Q_M1;
      ST_Q_M1:    state_next = ST_Q_M2;
      ST_Q_M2:    state_next = ST_Q_M3;
      ST_Q_M3:    state_next = ST_Q_M4;
      ST_Q_M4:    state_next = ST_Q_I;
      ST_Q_I:     state_next = ST_Q_IC;
      ST_Q_IC:    state_next = st.i_more ? ST_Q_IC : ST_Q_KC;
      ST_Q_KC: begin
        priority if (st.k_more) state_next = ST_Q_KC;
        else if (st.ik_lt)      state_next = ST_Q_SW2;
        else                    state_next = ST_Q_FIN;
      end
      ST_Q_SW2:   state_next = ST_Q_I;
      ST_Q_FIN:   state_next = st.push2 ? ST_Q_PUSH2 : ST_Q_POP;
      ST_Q_PUSH2: state_next = ST_Q_POP;
      ST_I_START: state_next = ST_I_SCAN;
      ST_I_SCAN:  state_next = st.scan_last ? ST_I_SWAP : ST_I_SCAN;
      ST_I_SWAP:  state_next = ST_I_SWAP2;
      ST_I_SWAP2: state_next = ST_I_NEXT;
      ST_I_NEXT:  state_next = st.is_done ? ST_FINISH : ST_I_SAVE;
      ST_I_SAVE:  state_next = ST_I_CMP;
      ST_I_CMP:   state_next = (st.is_shift && st.is_cont) ? ST_I_CMP : ST_I_PUT;
      ST_I_PUT:   state_next = ST_I_NEXT;
      ST_FINISH:  if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `IASS_ASSERT_NEXT(a_accept_decode, s_tvalid && s_tready, state == ST_DECODE)
  `IASS_ASSERT_NEXT(a_finish_out, cmd.load_out, m_tvalid && state == ST_IDLE)
  `IASS_ASSERT_NEXT(a_empty_insert, state == ST_Q_POP && st.stk_empty, state == ST_I_START)
  `IASS_ASSERT_IMPL(a_popw_after_pop, state == ST_Q_POPW, $past(state) == ST_Q_POP)

endmodule

FILE: src/iass_datapath.sv
// ----------------------------------------------------------------------------
// iass_datapath
// Element store, range stack, index registers, comparators and result registers.
// ----------------------------------------------------------------------------
module iass_datapath
  import iass_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int MIN_RUN    = MIN_RUN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        st,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_first,
  input  logic [IDX_W-1:0]  in_last,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              cfg_wr_en,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic [VAL_W-1:0]  out_data,
  output logic [IDX_W-1:0]  out_pos,
  output logic              out_found,
  output logic              out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = AW + 1;
  localparam int OW = (AW + 2 > IDX_W + 1) ? AW + 2 : IDX_W + 1;
  localparam int DW = DATA_WIDTH;

  // Configuration registers.
  logic [SIZE_W-1:0]        array_size;
  logic signed [BASE_W-1:0] index_base;

  // Captured command.
  cmd_t                 cmd_q;
  logic signed [OW-1:0] fi_q, li_q;
  logic signed [DW-1:0] val_q;

  // Stores.
  logic [DW-1:0]     mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DW-1:0]     mem_wdata, mem_rdata;
  logic [2*AW-1:0]   stk [STACK_DEPTH];
  logic              stk_we;
  logic [STK_AW-1:0] stk_raddr;
  logic [2*AW-1:0]   stk_wdata, stk_rdata;
  logic [SP_W-1:0]   sp;

  // Working registers.
  logic [AW-1:0]        lo, hi, mid, i, k, sl, sr, j, mpos, smid, srl;
  logic signed [NW-1:0] srr;
  logic [NW-1:0]        run;
  logic signed [DW-1:0] pa, pivot, ai, mval, lval, save;

  // Result registers.
  logic [VAL_W-1:0] res_data;
  logic [IDX_W-1:0] res_pos;
  logic             res_found, res_status;

  logic signed [DW-1:0]    rd;
  logic signed [IDX_W-1:0] first_s, last_s;
  logic signed [VAL_W-1:0] value_s;
  logic [NW-1:0]           n;
  logic signed [OW-1:0]    n_ext;
  logic [NW-1:0]           s_sum;
  logic [AW-1:0]           s_mid, q_lo, q_hi, q_mid;
  logic [31:0]             lo32, hi32, k32, sl32, sr32, run32, j32, mr32, stop32, base32;
  logic                    left, right, smaller_left, any_push, stk_room;
  logic [AW-1:0]           p1_lo, p1_hi, p2_lo, p2_hi;
  logic [SP_W-1:0]         sp_m1;
  logic [NW-1:0]           run_p1;

  assign rd      = mem_rdata;
  assign first_s = in_first;
  assign last_s  = in_last;
  assign value_s = in_value;

  // Elements in use, clamped to one through DEPTH.
  always_comb begin
    priority if (array_size == '0)              n = NW'(1);
    else if (32'(array_size) > 32'(DEPTH))      n = NW'(DEPTH);
    else                                        n = NW'(array_size);
  end
  assign n_ext = $signed({{(OW-NW){1'b0}}, n});

  assign s_sum  = {1'b0, srl} + NW'(srr);
  assign s_mid  = s_sum[NW-1:1];
  assign q_lo   = stk_rdata[2*AW-1:AW];
  assign q_hi   = stk_rdata[AW-1:0];
  assign q_mid  = q_lo + ((q_hi - q_lo) >> 1);
  assign sp_m1  = sp - SP_W'(1);
  assign run_p1 = run + NW'(1);

  assign lo32   = 32'(lo);
  assign hi32   = 32'(hi);
  assign k32    = 32'(k);
  assign sl32   = 32'(sl);
  assign sr32   = 32'(sr);
  assign run32  = 32'(run);
  assign j32    = 32'(j);
  assign mr32   = 32'(MIN_RUN);
  assign stop32 = (sr32 - sl32 > mr32) ? sl32 + mr32 : sr32;
  assign base32 = 32'(index_base);

  // Sub-ranges left after a partition; the larger goes on the stack first.
  assign left         = k32 > lo32 + mr32;
  assign right        = hi32 > k32 + mr32;
  assign smaller_left = (k32 - lo32) < (hi32 - k32);
  assign any_push     = left || right;
  assign stk_room     = sp < SP_W'(STACK_DEPTH);

  always_comb begin
    if ((left && right && smaller_left) || !left) begin
      p1_lo = k + AW'(1);
      p1_hi = hi;
    end else begin
      p1_lo = lo;
      p1_hi = k - AW'(1);
    end
    if (smaller_left) begin
      p2_lo = lo;
      p2_hi = k - AW'(1);
    end else begin
      p2_lo = k + AW'(1);
      p2_hi = hi;
    end
  end

  always_comb begin
    st.cmd       = cmd_q;
    st.bad_idx   = (fi_q < 0) || (fi_q >= n_ext);
    st.bad_rng   = (fi_q < 0) || (li_q >= n_ext) || (fi_q > li_q);
    st.single    = (fi_q == li_q);
    st.s_more    = $signed({1'b0, srl}) < srr;
    st.s_eq      = (rd == val_q);
    st.stk_empty = (sp == '0);
    st.q_degen   = (q_hi <= q_lo);
    st.i_more    = (i < hi) && (rd < pivot);
    st.k_more    = (k > lo) && (rd > pivot);
    st.ik_lt     = (i < k);
    st.push2     = left && right;
    st.scan_last = (run32 == stop32);
    st.is_done   = (run32 > sr32);
    st.is_shift  = (save < rd);
    st.is_cont   = (j32 > sl32 + 32'd1);
  end

  // Store and stack port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    stk_we    = 1'b0;
    stk_wdata = '0;
    stk_raddr = sp_m1[STK_AW-1:0];
    unique case (cmd.op)
      ST_DECODE: begin
        mem_raddr = fi_q[AW-1:0];
        if (cmd_q == CMD_WRITE && !st.bad_idx) begin
          mem_we    = 1'b1;
          mem_waddr = fi_q[AW-1:0];
          mem_wdata = val_q;
        end
        if (cmd_q == CMD_SORT && !st.bad_rng && !st.single) begin
          stk_we    = 1'b1;
          stk_wdata = {fi_q[AW-1:0], li_q[AW-1:0]};
        end
      end
      ST_S_LOOP:  mem_raddr = st.s_more ? s_mid : srl;
      ST_Q_POPW:  mem_raddr = q_mid;
      ST_Q_M1:    mem_raddr = hi;
      ST_Q_M2: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = (pa > rd) ? pa : rd;
        mem_raddr = lo;
      end
      ST_Q_M3: begin
        mem_we    = 1'b1;
        mem_waddr = mid;
        mem_wdata = rd;
      end
      ST_Q_M4: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = pivot;
      end
      ST_Q_I:     mem_raddr = i + AW'(1);
      ST_Q_IC:    mem_raddr = st.i_more ? i + AW'(1) : k - AW'(1);
      ST_Q_KC: begin
        mem_raddr = k - AW'(1);
        if (!st.k_more) begin
          mem_we    = 1'b1;
          mem_waddr = st.ik_lt ? i : lo;
          mem_wdata = rd;
        end
      end
      ST_Q_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = k;
        mem_wdata = ai;
      end
      ST_Q_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = k;
        mem_wdata = pivot;
        stk_we    = any_push && stk_room;
        stk_wdata = {p1_lo, p1_hi};
      end
      ST_Q_PUSH2: begin
        stk_we    = stk_room;
        stk_wdata = {p2_lo, p2_hi};
      end
      ST_I_START: mem_raddr = sl;
      ST_I_SCAN:  mem_raddr = run_p1[AW-1:0];
      ST_I_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = mpos;
        mem_wdata = lval;
      end
      ST_I_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = sl;
        mem_wdata = mval;
      end
      ST_I_NEXT:  mem_raddr = run[AW-1:0];
      ST_I_SAVE:  mem_raddr = j - AW'(1);
      ST_I_CMP: begin
        mem_raddr = j - AW'(2);
        if (st.is_shift) begin
          mem_we    = 1'b1;
          mem_waddr = j;
          mem_wdata = rd;
        end
      end
      ST_I_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = save;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[sp[STK_AW-1:0]] <= stk_wdata;
    stk_rdata <= stk[stk_raddr];
  end

  // Configuration and stack pointer. The pointer only leaves zero while a
  // sort runs and is back at zero when the sort ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      array_size <= SIZE_RESET;
      index_base <= '0;
      sp         <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_ARRAY_SIZE: array_size <= cfg_wdata[SIZE_W-1:0];
          REG_INDEX_BASE: index_base <= cfg_wdata[BASE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == ST_DECODE && stk_we) begin
        sp <= SP_W'(1);
      end else if (cmd.op == ST_Q_POP && !st.stk_empty) begin
        sp <= sp_m1;
      end else if (stk_we && (cmd.op == ST_Q_FIN || cmd.op == ST_Q_PUSH2)) begin
        sp <= sp + SP_W'(1);
      end
    end
  end

  // Working registers and results.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q <= cmd_t'(in_command);
      fi_q  <= OW'(first_s) - OW'(index_base);
      li_q  <= OW'(last_s) - OW'(index_base);
      val_q <= DW'(value_s);
    end
    unique case (cmd.op)
      ST_DECODE: begin
        res_data   <= '0;
        res_pos    <= '0;
        res_found  <= 1'b0;
        res_status <= (cmd_q == CMD_SORT) ? st.bad_rng :
                      (cmd_q == CMD_SEARCH) ? 1'b0 : st.bad_idx;
        sl  <= fi_q[AW-1:0];
        sr  <= li_q[AW-1:0];
        srl <= '0;
        srr <= $signed(n - NW'(1));
      end
      ST_RD:     res_data <= VAL_W'(rd);
      ST_S_LOOP: smid <= s_mid;
      ST_S_CMP: begin
        priority if (st.s_eq) begin
          res_found <= 1'b1;
          res_pos   <= IDX_W'(base32 + 32'(smid));
        end else if (val_q > rd) begin
          srl <= smid + AW'(1);
        end else begin
          srr <= $signed(NW'(smid) - NW'(1));
        end
      end
      ST_S_END: begin
        if (st.s_eq) begin
          res_found <= 1'b1;
          res_pos   <= IDX_W'(base32 + 32'(srl));
        end else begin
          res_pos   <= IDX_W'(base32 - 32'd1);
        end
      end
      ST_Q_POPW: begin
        lo  <= q_lo;
        hi  <= q_hi;
        mid <= q_mid;
      end
      ST_Q_M1:   pa <= rd;
      ST_Q_M2:   pivot <= (pa > rd) ? rd : pa;
      ST_Q_M4: begin
        i <= lo;
        k <= hi;
      end
      ST_Q_I:    i <= i + AW'(1);
      ST_Q_IC: begin
        if (st.i_more) begin
          i <= i + AW'(1);
        end else begin
          ai <= rd;
          k  <= k - AW'(1);
        end
      end
      ST_Q_KC:   if (st.k_more) k <= k - AW'(1);
      ST_I_START: run <= NW'(sl);
      ST_I_SCAN: begin
        priority if (run == NW'(sl)) begin
          lval <= rd;
          mval <= rd;
          mpos <= sl;
        end else if (rd < mval) begin
          mval <= rd;
          mpos <= run[AW-1:0];
        end
        if (!st.scan_last) run <= run_p1;
      end
      ST_I_SWAP2: run <= NW'(sl) + NW'(2);
      ST_I_NEXT:  j <= run[AW-1:0];
      ST_I_SAVE:  save <= rd;
      ST_I_CMP:   if (st.is_shift) j <= j - AW'(1);
      ST_I_PUT:   run <= run_p1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data   <= res_data;
      out_pos    <= res_pos;
      out_found  <= res_found;
      out_status <= res_status;
    end
  end

endmodule

FILE: src/integer_array_sort_search.sv
// ----------------------------------------------------------------------------
// integer_array_sort_search
// Signed integer array with element write and read, range sort and search.
// ----------------------------------------------------------------------------
// A transaction is accepted only in the idle state. Write and a bad index or range go
// from decode to finish; a read passes a read state; a search probes until a hit or
// until its range is empty; a sort runs partition passes, then an insertion pass.
// The result is loaded once the output slot is free, and only then is a new one taken.
// Reset (rst, synchronous) clears the sequencer, output valid and stack pointer and
// sets array_size to 1024, index_base to 0; the element store is not cleared.

module integer_array_sort_search
  import iass_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int MIN_RUN    = MIN_RUN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Input transaction.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [71:0]      s_tdata,   // first_index[16:0], last_index[33:17],
                                      // value[65:34], zero padding above
  input  logic [CMD_W-1:0] s_tuser,   // command[1:0]
  // Result transaction.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata,   // data_out[31:0], position[48:32],
                                      // found[49], status[50], zero padding above
  // Configuration writes.
  input  logic             cfg_wr_en,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t          cmd;
  dp_status_t       st;
  logic [VAL_W-1:0] out_data;
  logic [IDX_W-1:0] out_pos;
  logic             out_found, out_status;

  // The sequencer owns the handshakes; the datapath holds the store, the
  // range stack and all index and value registers.
  iass_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  iass_datapath #(
    .DEPTH      (DEPTH),
    .MIN_RUN    (MIN_RUN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_command (s_tuser),
    .in_first   (s_tdata[16:0]),
    .in_last    (s_tdata[33:17]),
    .in_value   (s_tdata[65:34]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_data   (out_data),
    .out_pos    (out_pos),
    .out_found  (out_found),
    .out_status (out_status)
  );

  assign m_tdata = {5'b0, out_status, out_found, out_pos, out_data};

endmodule
